// ===== rtl/hfps_pkg.sv =====
`timescale 1ns / 1ps
package hfps_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_PCOUNT = 2'd2,
        KIND_RCOUNT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_LARGE = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_STAT_RD,
        ST_OUT
    } state_t;

    localparam int unsigned MAX_PAGES       = 32;
    localparam int unsigned SLOTS_PER_PAGE  = 64;
    localparam int unsigned HEADER_BYTES    = 16;
    localparam int unsigned RECORD_OVERHEAD = 4;

endpackage

// ===== rtl/heap_file_page_store.sv =====
`timescale 1ns / 1ps
// Heap file page store. Insert places a record first-fit by walking the page
// table one page at a time (read, then compare). Search reads the stored keys
// one at a time from the key memory (read, then compare), stepping on to each
// next page in turn. Status emits page_count+1 words.
// The block takes one command at a time; in_ready is low while one is at work.
// The result register waits for out_ready before the next step continues.
module heap_file_page_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] key,
    input  logic [15:0] record_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [1:0]  error,
    output logic        found,
    output logic [4:0]  page_index,
    output logic [5:0]  slot_index,
    output logic [6:0]  count,
    output logic        last
);
    import hfps_pkg::*;

    localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned CW = $clog2(MAX_PAGES + 1);
    localparam int unsigned SW = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int unsigned NW = $clog2(SLOTS_PER_PAGE + 1);
    localparam int unsigned AW = PW + SW;
    localparam int unsigned DEPTH = 1 << AW;

    state_t state_reg, state_next;
    logic [15:0] psize_reg;
    logic [CW-1:0] pcount_reg;
    logic [15:0] free_mem [MAX_PAGES];
    logic [NW-1:0] rcnt_mem [MAX_PAGES];
    logic [31:0] key_reg;
    logic [16:0] need_reg;
    logic [CW-1:0] p_reg;
    logic [NW-1:0] s_reg;
    logic [15:0] free_rd_reg;
    logic [NW-1:0] rcnt_rd_reg;
    logic [1:0]  o_kind_reg, o_err_reg;
    logic        o_found_reg, o_last_reg, o_done_reg;
    logic [4:0]  o_page_reg;
    logic [5:0]  o_slot_reg;
    logic [6:0]  o_cnt_reg;

    logic        kwe;
    logic [AW-1:0] kwaddr, kraddr;
    logic [31:0] krdata;
    logic [16:0] usable;
    logic        fits;
    logic [PW-1:0] pi;

    assign pi = p_reg[PW-1:0];
    assign usable = (psize_reg >= 16'(HEADER_BYTES)) ?
        17'(psize_reg - 16'(HEADER_BYTES)) : 17'd0;
    assign fits = ({1'b0, free_rd_reg} >= need_reg) &&
        (rcnt_rd_reg < NW'(SLOTS_PER_PAGE));

    hfps_key_ram #(.DEPTH(DEPTH), .AW(AW)) u_keys (
        .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(key_reg),
        .raddr(kraddr), .rdata(krdata)
    );

    assign kraddr = {pi, s_reg[SW-1:0]};
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign kind = o_kind_reg;
    assign error = o_err_reg;
    assign found = o_found_reg;
    assign page_index = o_page_reg;
    assign slot_index = o_slot_reg;
    assign count = o_cnt_reg;
    assign last = o_last_reg;

    always_comb
    begin
        kwe = 1'b0;
        kwaddr = {pi, s_reg[SW-1:0]};
        if (state_reg == ST_INS_CHK && p_reg < pcount_reg && fits)
        begin
            kwe = 1'b1;
            kwaddr = {pi, rcnt_rd_reg[SW-1:0]};
        end
        else if (state_reg == ST_INS_CHK && !(p_reg < pcount_reg) &&
                 need_reg <= usable && pcount_reg < CW'(MAX_PAGES))
        begin
            kwe = 1'b1;
            kwaddr = {pi, SW'(0)};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_INSERT: state_next = ST_INS_RD;
                        CMD_SEARCH: state_next = ST_SRCH_RD;
                        CMD_STATUS: state_next = ST_STAT_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_INS_RD:   state_next = ST_INS_CHK;
            ST_INS_CHK:
                if (p_reg < pcount_reg && !fits) state_next = ST_INS_RD;
                else state_next = ST_OUT;
            ST_SRCH_RD:
                if (p_reg >= pcount_reg) state_next = ST_OUT;
                else if (s_reg >= rcnt_rd_reg) state_next = ST_SRCH_RD;
                else state_next = ST_SRCH_CHK;
            ST_SRCH_CHK:
                if (krdata == key_reg) state_next = ST_OUT;
                else state_next = ST_SRCH_RD;
            ST_STAT_RD:  state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                begin
                    if (o_done_reg) state_next = ST_IDLE;
                    else state_next = ST_STAT_RD;
                end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            psize_reg  <= 16'd4096;
            pcount_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) psize_reg <= cfg_wdata;
            if (state_reg == ST_INS_CHK && !(p_reg < pcount_reg) &&
                need_reg <= usable && pcount_reg < CW'(MAX_PAGES))
                pcount_reg <= pcount_reg + 1'b1;
        end
    end

    // page table and sequencer datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                key_reg  <= key;
                need_reg <= 17'(record_size) + 17'(RECORD_OVERHEAD);
                p_reg    <= '0;
                s_reg    <= '0;
                o_done_reg <= 1'b1;
                o_kind_reg <= KIND_PCOUNT;
                o_err_reg <= ERR_OK;
                o_found_reg <= 1'b0;
                o_page_reg <= '0;
                o_slot_reg <= '0;
                o_cnt_reg <= '0;
                o_last_reg <= 1'b1;
                free_rd_reg <= free_mem[0];
                rcnt_rd_reg <= rcnt_mem[0];
            end
            ST_INS_RD:
            begin
                free_rd_reg <= free_mem[pi];
                rcnt_rd_reg <= rcnt_mem[pi];
            end
            ST_INS_CHK:
            begin
                o_kind_reg <= KIND_INSERT;
                o_last_reg <= 1'b1;
                o_done_reg <= 1'b1;
                if (p_reg < pcount_reg)
                begin
                    if (fits)
                    begin
                        free_mem[pi] <= free_rd_reg - need_reg[15:0];
                        rcnt_mem[pi] <= rcnt_rd_reg + 1'b1;
                        o_page_reg <= 5'(p_reg);
                        o_slot_reg <= 6'(rcnt_rd_reg);
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                else if (need_reg > usable)
                begin
                    o_err_reg <= ERR_LARGE;
                end
                else if (pcount_reg >= CW'(MAX_PAGES))
                begin
                    o_err_reg <= ERR_FULL;
                end
                else
                begin
                    free_mem[pi] <= 16'(usable - need_reg);
                    rcnt_mem[pi] <= NW'(1);
                    o_page_reg <= 5'(p_reg);
                end
            end
            ST_SRCH_RD:
            begin
                o_kind_reg <= KIND_SEARCH;
                if (p_reg < pcount_reg)
                begin
                    if (s_reg >= rcnt_mem[pi] || s_reg >= NW'(SLOTS_PER_PAGE))
                    begin
                        p_reg <= p_reg + 1'b1;
                        s_reg <= '0;
                        rcnt_rd_reg <= rcnt_mem[PW'(p_reg + 1'b1)];
                    end
                    else
                    begin
                        rcnt_rd_reg <= rcnt_mem[pi];
                    end
                end
            end
            ST_SRCH_CHK:
            begin
                if (krdata == key_reg)
                begin
                    o_found_reg <= 1'b1;
                    o_page_reg <= 5'(p_reg);
                    o_slot_reg <= 6'(s_reg);
                end
                else
                begin
                    s_reg <= s_reg + 1'b1;
                end
            end
            ST_STAT_RD:
            begin
                if (o_kind_reg == KIND_PCOUNT && o_done_reg)
                begin
                    o_cnt_reg  <= 7'(pcount_reg);
                    o_last_reg <= (pcount_reg == '0);
                    o_done_reg <= (pcount_reg == '0);
                end
                else
                begin
                    o_kind_reg <= KIND_RCOUNT;
                    o_page_reg <= 5'(p_reg);
                    o_cnt_reg  <= 7'(rcnt_mem[pi]);
                    o_last_reg <= (p_reg + 1'b1 == pcount_reg);
                    o_done_reg <= (p_reg + 1'b1 == pcount_reg);
                    p_reg <= p_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready) o_kind_reg <= KIND_RCOUNT;
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== rtl/hfps_key_ram.sv =====
`timescale 1ns / 1ps
module hfps_key_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import hfps_pkg::*;

    localparam int NPAGES = 32;
    localparam int NSLOTS = 64;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
        logic [15:0] rsize;
    } req_t;

    typedef struct packed {
        kind_t      kind;
        err_t       err;
        logic       found;
        logic [4:0] page;
        logic [5:0] slot;
        logic [6:0] count;
        logic       last;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = 2'd0;
    logic signed [31:0] key = 32'sd0;
    logic [15:0] record_size = 16'd0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] kind;
    logic [1:0] error;
    logic found;
    logic [4:0] page_index;
    logic [5:0] slot_index;
    logic [6:0] count;
    logic last;

    heap_file_page_store dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key),
        .record_size(record_size), .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .error(error), .found(found), .page_index(page_index),
        .slot_index(slot_index), .count(count), .last(last)
    );

    always #6 clk = ~clk;

    // shadow of the page table
    logic [15:0] cur_page_size;
    int unsigned num_pages;
    logic [15:0] free_bytes [NPAGES];
    int unsigned rec_count [NPAGES];
    logic [31:0] stored_keys [NPAGES][NSLOTS];

    req_t  pending_reqs[$];
    word_t expected_words[$];
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_off = 1'b0;
    int    errors = 0;
    int    n_sent = 0;
    int    n_words = 0;
    int    n_hits = 0;
    int    n_large = 0;
    int    n_full = 0;

    function automatic word_t mk_word(kind_t k, err_t e, logic f, int p, int s,
                                      int c, logic l);
        word_t w;
        w.kind = k; w.err = e; w.found = f; w.page = p[4:0]; w.slot = s[5:0];
        w.count = c[6:0]; w.last = l;
        return w;
    endfunction

    function automatic void add_word(word_t w);
        expected_words = {expected_words, w};
    endfunction

    function automatic void add_req(req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    task automatic predict_page_store(req_t r);
        int unsigned need;
        int unsigned usable;
        bit done;
        done = 1'b0;
        case (r.cmd)
            CMD_INSERT:
            begin
                need = r.rsize + RECORD_OVERHEAD;
                usable = (cur_page_size >= HEADER_BYTES) ? cur_page_size - HEADER_BYTES : 0;
                for (int p = 0; p < num_pages && !done; p++)
                begin
                    if (free_bytes[p] >= need && rec_count[p] < NSLOTS)
                    begin
                        free_bytes[p] = 16'(free_bytes[p] - need);
                        stored_keys[p][rec_count[p]] = r.key;
                        add_word(mk_word(KIND_INSERT, ERR_OK, 0, p, rec_count[p], 0, 1));
                        rec_count[p]++;
                        done = 1'b1;
                    end
                end
                if (!done)
                begin
                    if (need > usable)
                    begin
                        add_word(mk_word(KIND_INSERT, ERR_LARGE, 0, 0, 0, 0, 1));
                        n_large++;
                    end
                    else if (num_pages >= NPAGES)
                    begin
                        add_word(mk_word(KIND_INSERT, ERR_FULL, 0, 0, 0, 0, 1));
                        n_full++;
                    end
                    else
                    begin
                        free_bytes[num_pages] = 16'(usable - need);
                        rec_count[num_pages] = 1;
                        stored_keys[num_pages][0] = r.key;
                        add_word(mk_word(KIND_INSERT, ERR_OK, 0, num_pages, 0, 0, 1));
                        num_pages++;
                    end
                end
            end
            CMD_SEARCH:
            begin
                for (int p = 0; p < num_pages && !done; p++)
                    for (int s = 0; s < rec_count[p] && !done; s++)
                        if (stored_keys[p][s] == r.key)
                        begin
                            add_word(mk_word(KIND_SEARCH, ERR_OK, 1, p, s, 0, 1));
                            done = 1'b1;
                            n_hits++;
                        end
                if (!done)
                    add_word(mk_word(KIND_SEARCH, ERR_OK, 0, 0, 0, 0, 1));
            end
            CMD_STATUS:
            begin
                add_word(mk_word(KIND_PCOUNT, ERR_OK, 0, 0, 0, num_pages,
                                 num_pages == 0));
                for (int p = 0; p < num_pages; p++)
                    add_word(mk_word(KIND_RCOUNT, ERR_OK, 0, p, 0,
                                     rec_count[p], p + 1 == num_pages));
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    predict_page_store(r);
                    n_sent++;
                    cmd <= r.cmd;
                    key <= r.key;
                    record_size <= r.rsize;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                word_t w;
                n_words++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word kind=%0d", kind);
                    errors++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (kind != w.kind)
                    begin $error("kind exp %0d got %0d", w.kind, kind); errors++; end
                    if (error != w.err)
                    begin $error("error exp %0d got %0d", w.err, error); errors++; end
                    if (found != w.found)
                    begin $error("found exp %0d got %0d", w.found, found); errors++; end
                    if (page_index != w.page)
                    begin $error("page_index exp %0d got %0d", w.page, page_index); errors++; end
                    if (slot_index != w.slot)
                    begin $error("slot_index exp %0d got %0d", w.slot, slot_index); errors++; end
                    if (count != w.count)
                    begin $error("count exp %0d got %0d", w.count, count); errors++; end
                    if (last != w.last)
                    begin $error("last exp %0d got %0d", w.last, last); errors++; end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic req_t mk_req(cmd_t c, logic [31:0] k, logic [15:0] s);
        req_t r;
        r.cmd = c; r.key = k; r.rsize = s;
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_page_size(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_page_size = v;
    endtask

    // mostly inserts of small records with keys reused, so searches hit
    task automatic random_burst(int n, int max_size);
        logic [31:0] k;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            k = ($urandom_range(1)) ? $urandom_range(40) : $urandom;
            if (sel < 55)
                add_req(mk_req(CMD_INSERT, k, 16'($urandom_range(max_size))));
            else if (sel < 85)
                add_req(mk_req(CMD_SEARCH, k, 16'($urandom)));
            else if (sel < 95)
                add_req(mk_req(CMD_STATUS, $urandom, 16'($urandom)));
            else if (sel < 98)
                add_req(mk_req(CMD_INSERT, k, 16'($urandom)));
            else
                add_req(mk_req(CMD_NONE, $urandom, 16'($urandom)));
        end
    endtask

    initial
    begin
        cur_page_size = 16'd4096;
        num_pages = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        add_req(mk_req(CMD_STATUS, 0, 0));
        add_req(mk_req(CMD_SEARCH, 32'h8000_0000, 0));
        add_req(mk_req(CMD_INSERT, 32'h8000_0000, 0));
        add_req(mk_req(CMD_INSERT, 32'h7FFF_FFFF, 16'd4076));
        add_req(mk_req(CMD_INSERT, 32'hFFFF_FFFF, 16'd4077));
        add_req(mk_req(CMD_INSERT, 32'h0, 16'hFFFF));
        add_req(mk_req(CMD_SEARCH, 32'h7FFF_FFFF, 16'hFFFF));
        add_req(mk_req(CMD_SEARCH, 32'h1234_5678, 0));
        add_req(mk_req(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF));
        add_req(mk_req(CMD_STATUS, 0, 0));
        drain();

        // tiny pages: 4 bytes usable, record of size 0 fills one page each
        write_page_size(16'd20);
        for (int i = 0; i < 33; i++)
            add_req(mk_req(CMD_INSERT, i, 0));
        add_req(mk_req(CMD_INSERT, 99, 1));
        add_req(mk_req(CMD_STATUS, 0, 0));
        drain();

        // below header size: nothing fits; then the largest page
        write_page_size(16'd8);
        add_req(mk_req(CMD_INSERT, 7, 0));
        drain();
        write_page_size(16'hFFFF);
        add_req(mk_req(CMD_INSERT, 7, 16'd65515));
        drain();

        send_idle_pct = 0; recv_stall_pct = 0;
        random_burst(60, 300);
        drain();

        // long receiver hold-off while the sender keeps going
        hold_off = 1'b1;
        random_burst(10, 300);
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
        drain();

        write_page_size(16'd200);
        send_idle_pct = 64; recv_stall_pct = 0;
        random_burst(70, 60);
        drain();

        write_page_size(16'd1000);
        send_idle_pct = 0; recv_stall_pct = 64;
        random_burst(70, 100);
        drain();

        send_idle_pct = 32; recv_stall_pct = 32;
        random_burst(40, 200);
        drain();

        $display("sent %0d commands, checked %0d words (%0d search hits, %0d too large, %0d full)",
                 n_sent, n_words, n_hits, n_large, n_full);
        if (errors == 0)
            $display("heap_file_page_store test passed");
        else
            $display("heap_file_page_store test failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("heap_file_page_store test failed");
        $finish;
    end
endmodule
